[src/bucket_offset_bit_packer_macros.svh]
// Assertion macros for the bucket offset bit packer.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef BUCKET_OFFSET_BIT_PACKER_MACROS_SVH
`define BUCKET_OFFSET_BIT_PACKER_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every rising edge outside reset
`define BOP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen outside reset
`define BOP_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BOP_ASSERT(lbl, clk, rst_n, prop, msg)
`define BOP_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

[src/bop_pkg.sv]
// Shared constants, codes and stage types for the bucket offset bit packer.
// No dependencies; used by bop_lookup, bop_packer and bucket_offset_bit_packer.
`timescale 1ns / 1ps

package bop_pkg;

    localparam int MAX_BUCKETS  = 16;
    localparam int SLOT_BITS    = $clog2(MAX_BUCKETS);
    localparam int VALUE_BITS   = 32;
    localparam int WIDTH_BITS   = 6;
    localparam int IW_BITS      = 3;
    localparam int BCNT_BITS    = 5;
    localparam int BYTE_BITS    = 8;
    localparam int IDX_FLD_BITS = 7;                          // widest index field
    localparam int FIELD_BITS   = IDX_FLD_BITS + VALUE_BITS;  // index + offset
    localparam int FL_BITS      = 6;
    localparam int PEND_BITS    = 7;
    localparam int PCNT_BITS    = 3;
    localparam int ACC_BITS     = FIELD_BITS + PEND_BITS;     // 46
    localparam int ALIGN_BITS   = 48;
    localparam int MAX_BYTES    = 5;
    localparam int QUEUE_BITS   = MAX_BYTES * BYTE_BITS;
    localparam int LEFT_BITS    = 3;
    localparam int SEARCH_STEPS = $clog2(MAX_BUCKETS + 1);

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_ENCODE = 2'd1,
        KIND_FLUSH  = 2'd2
    } t_kind;

    // configuration register indexes (paddr word address)
    localparam logic CFG_INDEX_WIDTH = 1'b0;
    localparam logic CFG_BKT_NUM     = 1'b1;

    typedef struct packed {
        logic [IW_BITS-1:0]   index_width;
        logic [BCNT_BITS-1:0] bkt_num;
    } t_cfg;

    typedef struct packed {
        logic [1:0]                   kind;
        logic [SLOT_BITS-1:0]         entry_slot;
        logic signed [VALUE_BITS-1:0] entry_start;
        logic [WIDTH_BITS-1:0]        entry_width;
        logic signed [VALUE_BITS-1:0] sample;
    } t_s0;

    typedef struct packed {
        logic                  is_flush;
        logic                  below;
        logic [SLOT_BITS-1:0]  idx;
        logic [VALUE_BITS-1:0] sample;
    } t_s1;

    typedef struct packed {
        logic                  is_flush;
        logic                  below;
        logic [FIELD_BITS-1:0] field;
        logic [FL_BITS-1:0]    fl;
    } t_s2;

endpackage

[src/bop_lookup.sv]
// Bucket tables, bucket search and offset field formation (two register stages).
// Depends on bop_pkg.
`timescale 1ns / 1ps

module bop_lookup (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bop_pkg::t_cfg i_cfg,
    input  bop_pkg::t_s0  i_s0,
    input  logic          i_s0_adv,
    output logic          o_s1_free,
    input  logic          i_pk_free,
    output bop_pkg::t_s2  o_s2,
    output logic          o_s2_vld
);

    logic signed [bop_pkg::VALUE_BITS-1:0] r_start_tab [bop_pkg::MAX_BUCKETS];
    logic [bop_pkg::WIDTH_BITS-1:0]        r_width_tab [bop_pkg::MAX_BUCKETS];

    bop_pkg::t_s1 r_s1;
    logic         r_s1_vld;
    bop_pkg::t_s2 r_s2;
    logic         r_s2_vld;

    logic [bop_pkg::MAX_BUCKETS-1:0] ge;
    logic [bop_pkg::BCNT_BITS-1:0]   first;
    bop_pkg::t_s1                    n_s1;
    logic                            s1_ld;
    logic                            s1_adv;
    logic                            s2_free;
    logic                            s2_adv;

    logic [bop_pkg::VALUE_BITS-1:0]   st;
    logic [bop_pkg::WIDTH_BITS-1:0]   wraw;
    logic [bop_pkg::WIDTH_BITS-1:0]   w;
    logic [bop_pkg::VALUE_BITS-1:0]   offm;
    logic [bop_pkg::IDX_FLD_BITS-1:0] idxm;
    bop_pkg::t_s2                     n_s2;

    // table writes: a load leaves S0
    always_ff @(posedge i_clk) begin
        if (i_s0_adv && i_s0.kind == bop_pkg::KIND_LOAD) begin
            r_start_tab[i_s0.entry_slot] <= i_s0.entry_start;
            r_width_tab[i_s0.entry_slot] <= i_s0.entry_width;
        end
    end

    // compare against every start at once, then walk the search over the flags
    always_comb begin
        for (int i = 0; i < bop_pkg::MAX_BUCKETS; i++) begin
            ge[i] = !(i_s0.sample < r_start_tab[i]);
        end
    end

    always_comb begin
        logic [bop_pkg::BCNT_BITS-1:0] count;
        logic [bop_pkg::BCNT_BITS-1:0] step;
        logic [bop_pkg::BCNT_BITS-1:0] it;
        first = '0;
        step  = '0;
        it    = '0;
        if (i_cfg.bkt_num > bop_pkg::BCNT_BITS'(bop_pkg::MAX_BUCKETS)) begin
            count = bop_pkg::BCNT_BITS'(bop_pkg::MAX_BUCKETS);
        end else begin
            count = i_cfg.bkt_num;
        end
        for (int k = 0; k < bop_pkg::SEARCH_STEPS; k++) begin
            if (count != '0) begin
                step = count >> 1;
                it   = first + step;
                if (ge[it[bop_pkg::SLOT_BITS-1:0]]) begin
                    first = it + 1'b1;
                    count = count - step - 1'b1;
                end else begin
                    count = step;
                end
            end
        end
    end

    always_comb begin
        n_s1.is_flush = (i_s0.kind == bop_pkg::KIND_FLUSH);
        n_s1.below    = (first == '0);
        n_s1.idx      = bop_pkg::SLOT_BITS'(first - 1'b1);
        n_s1.sample   = i_s0.sample;
    end

    // loads and unused kinds stop at S0
    assign s1_ld     = i_s0_adv && (i_s0.kind == bop_pkg::KIND_ENCODE ||
                                    i_s0.kind == bop_pkg::KIND_FLUSH);
    assign s2_adv    = r_s2_vld && i_pk_free;
    assign s2_free   = !r_s2_vld || i_pk_free;
    assign s1_adv    = r_s1_vld && s2_free;
    assign o_s1_free = !r_s1_vld || s2_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_ld) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ld) begin
            r_s1 <= n_s1;
        end
    end

    // offset and index fields, joined into one right-aligned field
    always_comb begin
        st   = r_start_tab[r_s1.idx];
        wraw = r_width_tab[r_s1.idx];
        if (wraw > bop_pkg::WIDTH_BITS'(bop_pkg::VALUE_BITS)) begin
            w = bop_pkg::WIDTH_BITS'(bop_pkg::VALUE_BITS);
        end else begin
            w = wraw;
        end
        offm = (r_s1.sample - st) & ~({bop_pkg::VALUE_BITS{1'b1}} << w);
        idxm = bop_pkg::IDX_FLD_BITS'(r_s1.idx)
             & ~({bop_pkg::IDX_FLD_BITS{1'b1}} << i_cfg.index_width);
        n_s2.is_flush = r_s1.is_flush;
        n_s2.below    = r_s1.below;
        n_s2.field    = (bop_pkg::FIELD_BITS'(idxm) << w) | bop_pkg::FIELD_BITS'(offm);
        n_s2.fl       = bop_pkg::FL_BITS'(i_cfg.index_width) + w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (s1_adv) begin
            r_s2_vld <= 1'b1;
        end else if (s2_adv) begin
            r_s2_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2     = r_s2;
    assign o_s2_vld = r_s2_vld;

endmodule

[src/bop_packer.sv]
// Bit packer: pending bits, byte split and the result register that drains bytes.
// Depends on bop_pkg and bucket_offset_bit_packer_macros.svh.
`timescale 1ns / 1ps
`include "bucket_offset_bit_packer_macros.svh"

module bop_packer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  bop_pkg::t_s2 i_s2,
    input  logic         i_s2_vld,
    output logic         o_pk_free,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [7:0]   o_out_byte,
    output logic         o_byte_valid,
    output logic         o_below_range,
    output logic         o_run_end
);

    logic [bop_pkg::LEFT_BITS-1:0]  r_left;
    logic [bop_pkg::QUEUE_BITS-1:0] r_data;
    logic                           r_bvalid;
    logic                           r_below;
    logic [bop_pkg::PEND_BITS-1:0]  r_pend_bits;
    logic [bop_pkg::PCNT_BITS-1:0]  r_pend_cnt;

    logic [bop_pkg::LEFT_BITS-1:0]  n_left;
    logic [bop_pkg::QUEUE_BITS-1:0] n_data;
    logic                           n_bvalid;
    logic                           n_below;
    logic [bop_pkg::PEND_BITS-1:0]  n_pend_bits;
    logic [bop_pkg::PCNT_BITS-1:0]  n_pend_cnt;

    logic                             take;
    logic                             out_acc;
    logic [bop_pkg::ACC_BITS-1:0]     acc;
    logic [bop_pkg::FL_BITS-1:0]      nb;
    logic [bop_pkg::LEFT_BITS-1:0]    nbytes;
    logic [2:0]                       rem;
    logic [bop_pkg::ALIGN_BITS-1:0]   aligned;
    logic [bop_pkg::BYTE_BITS-1:0]    flush_byte;

    assign o_valid   = (r_left != '0);
    assign out_acc   = o_valid && !i_stall;
    assign o_pk_free = (r_left == '0) || (r_left == bop_pkg::LEFT_BITS'(1) && !i_stall);
    assign take      = i_s2_vld && o_pk_free;

    always_comb begin
        acc     = (bop_pkg::ACC_BITS'(r_pend_bits) << i_s2.fl)
                | bop_pkg::ACC_BITS'(i_s2.field);
        nb      = bop_pkg::FL_BITS'(r_pend_cnt) + i_s2.fl;
        nbytes  = nb[5:3];
        rem     = nb[2:0];
        // push the completed bytes to the top, first bit in the MSB
        aligned = bop_pkg::ALIGN_BITS'(acc)
                << (bop_pkg::FL_BITS'(bop_pkg::ALIGN_BITS) - nb);
        flush_byte = bop_pkg::BYTE_BITS'(
            {1'b0, r_pend_bits} << (4'(bop_pkg::BYTE_BITS) - {1'b0, r_pend_cnt}));
    end

    always_comb begin
        n_left      = r_left;
        n_data      = r_data;
        n_bvalid    = r_bvalid;
        n_below     = r_below;
        n_pend_bits = r_pend_bits;
        n_pend_cnt  = r_pend_cnt;
        if (take) begin
            n_left  = bop_pkg::LEFT_BITS'(1);
            n_below = 1'b0;
            n_data  = '0;
            if (i_s2.is_flush) begin
                n_bvalid = (r_pend_cnt != '0);
                if (r_pend_cnt != '0) begin
                    n_data = {flush_byte, {(bop_pkg::QUEUE_BITS-bop_pkg::BYTE_BITS){1'b0}}};
                end
                n_pend_bits = '0;
                n_pend_cnt  = '0;
            end else if (i_s2.below) begin
                n_bvalid = 1'b0;
                n_below  = 1'b1;
            end else begin
                n_bvalid    = (nbytes != '0);
                if (nbytes != '0) begin
                    n_left = nbytes;
                    n_data = aligned[bop_pkg::ALIGN_BITS-1 -: bop_pkg::QUEUE_BITS];
                end
                n_pend_bits = acc[bop_pkg::PEND_BITS-1:0]
                            & bop_pkg::PEND_BITS'((8'd1 << rem) - 8'd1);
                n_pend_cnt  = rem;
            end
        end else if (out_acc) begin
            // advance to the next byte of the run
            n_data = r_data << bop_pkg::BYTE_BITS;
            n_left = r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
        end else begin
            r_left      <= n_left;
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data   <= n_data;
        r_bvalid <= n_bvalid;
        r_below  <= n_below;
    end

    assign o_out_byte    = r_data[bop_pkg::QUEUE_BITS-1 -: bop_pkg::BYTE_BITS];
    assign o_byte_valid  = r_bvalid;
    assign o_below_range = r_below;
    assign o_run_end     = (r_left == bop_pkg::LEFT_BITS'(1));

    `BOP_ASSERT(a_flush_clears, i_clk, i_rst_n, take && i_s2.is_flush |=> r_pend_cnt == '0, "flush left bits pending")
    `BOP_NEVER(a_left_range, i_clk, i_rst_n, r_left > bop_pkg::LEFT_BITS'(bop_pkg::MAX_BYTES), "too many results queued")
    `BOP_NEVER(a_below_no_byte, i_clk, i_rst_n, o_valid && o_below_range && o_byte_valid, "below-range result carries a byte")
    `BOP_ASSERT(a_run_continues, i_clk, i_rst_n, o_valid && !i_stall && !o_run_end |=> o_valid && o_byte_valid, "byte run cut short")

endmodule

[src/bucket_offset_bit_packer.sv]
// An accepted request passes the S0, S1 and S2 registers, then the result register (out).
// Throughput: one request per cycle while each gives one result and i_stall is low; an
// encode completing k bytes (up to five) holds the byte-wide result register till all drain.
// Reset (i_rst_n low, synchronous): clears stage valids, pending bits, the index width to 0
// and the bucket count to 1; the bucket tables are not cleared and hold nothing until loaded.
// Top level: request register and configuration port. Depends on bop_pkg, bop_lookup,
// bop_packer.
`timescale 1ns / 1ps

module bucket_offset_bit_packer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [1:0]                           i_kind,
    input  logic [bop_pkg::SLOT_BITS-1:0]        i_entry_slot,
    input  logic signed [bop_pkg::VALUE_BITS-1:0] i_entry_start,
    input  logic [bop_pkg::WIDTH_BITS-1:0]       i_entry_width,
    input  logic signed [bop_pkg::VALUE_BITS-1:0] i_sample,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [7:0]                           o_out_byte,
    output logic                                 o_byte_valid,
    output logic                                 o_below_range,
    output logic                                 o_run_end,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    bop_pkg::t_cfg r_cfg;
    bop_pkg::t_s0  r_s0;
    logic          r_s0_vld;

    logic          s1_free;
    logic          s0_adv;
    logic          in_acc;
    logic          cfg_wr;
    logic          pk_free;
    bop_pkg::t_s2  s2;
    logic          s2_vld;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.index_width <= '0;
            r_cfg.bkt_num     <= bop_pkg::BCNT_BITS'(1);
        end else if (cfg_wr) begin
            case (paddr[2])
                bop_pkg::CFG_INDEX_WIDTH: r_cfg.index_width <= pwdata[bop_pkg::IW_BITS-1:0];
                bop_pkg::CFG_BKT_NUM:     r_cfg.bkt_num     <= pwdata[bop_pkg::BCNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            bop_pkg::CFG_INDEX_WIDTH: prdata = 32'(r_cfg.index_width);
            bop_pkg::CFG_BKT_NUM:     prdata = 32'(r_cfg.bkt_num);
            default:                  prdata = '0;
        endcase
    end

    // request register: hold while the search stage is full
    assign s0_adv  = r_s0_vld && s1_free;
    assign o_stall = r_s0_vld && !s1_free;
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (in_acc) begin
            r_s0_vld <= 1'b1;
        end else if (s0_adv) begin
            r_s0_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s0.kind        <= i_kind;
            r_s0.entry_slot  <= i_entry_slot;
            r_s0.entry_start <= i_entry_start;
            r_s0.entry_width <= i_entry_width;
            r_s0.sample      <= i_sample;
        end
    end

    bop_lookup u_lookup (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_s0      (r_s0),
        .i_s0_adv  (s0_adv),
        .o_s1_free (s1_free),
        .i_pk_free (pk_free),
        .o_s2      (s2),
        .o_s2_vld  (s2_vld)
    );

    bop_packer u_packer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s2          (s2),
        .i_s2_vld      (s2_vld),
        .o_pk_free     (pk_free),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_below_range (o_below_range),
        .o_run_end     (o_run_end)
    );

endmodule
